/* design/hfag_pkg.sv */
// Package with the shared codes and item types of the heap floor admission gate.
package hfag_pkg;

   // Request action codes.
   localparam logic [2:0] ACT_CHECK_SIZE  = 3'd0;
   localparam logic [2:0] ACT_CHECK_COUNT = 3'd1;
   localparam logic [2:0] ACT_SET_CLASS   = 3'd2;
   localparam logic [2:0] ACT_FORGET_TASK = 3'd3;
   localparam logic [2:0] ACT_QUERY_AVAIL = 3'd4;

   // Caller class codes.
   localparam logic [1:0] CLASS_SYSTEM   = 2'd0;
   localparam logic [1:0] CLASS_GENERAL  = 2'd1;
   localparam logic [1:0] CLASS_REALTIME = 2'd2;

   // Extra reserve that general callers must leave above the floor.
   localparam logic [24:0] RT_RESERVE = 25'd8192;

   // One-hot view of the decoded action.
   typedef struct packed {
      logic chk;
      logic mul;
      logic set;
      logic fgt;
      logic qry;
   } hfag_ops_type;

   // Classified request as it waits between the front and the back.
   typedef struct packed {
      hfag_ops_type ops;
      logic         own;
      logic [1:0]   own_class;
      logic [1:0]   class_in;
      logic [31:0]  need;
      logic         ovf;
      logic [31:0]  free_bytes;
   } hfag_item_type;

endpackage

/* design/heap_floor_admission_gate.sv */
// Top level of the heap floor admission gate.
//
// Requests arrive on the req_ channel (valid/stall) and each one yields exactly
// one result on the rsp_ channel (valid/stall), in order. The csr_ channel
// writes the 24-bit floor; a write also clears the refusal counter. csr_ready
// is always high, and the floor is meant to be written only while idle.
// The front decodes the action and forms the byte demand (one 32x32 multiply);
// a two-entry queue holds classified requests until the back end takes them.
// The back end scans the class table one entry per cycle through its memory
// read port. For each request it takes the request from the queue, scans every
// entry, finishes the last compare, forms the floor and issues the result; only
// then does it take the next request from the queue.
// req_stall rises only when the queue is full. When the receiver stalls, the
// result is held in the output register, the back end waits with the next
// result, and the queue keeps taking requests until it fills.
// Reset empties the class table, clears the floor, the refusal counter, the
// queue and the valid flag of the output register.
module heap_floor_admission_gate
   import hfag_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8,
   parameter int TASK_ID_BITS  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_action,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   input  logic                    req_has_own_class,
   input  logic [1:0]              req_own_class,
   input  logic [1:0]              req_class_in,
   input  logic [31:0]             req_size,
   input  logic [31:0]             req_count,
   input  logic [31:0]             req_free_bytes,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_granted,
   output logic [1:0]              rsp_class_before,
   output logic [31:0]             rsp_available,
   output logic [31:0]             rsp_refusal_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [23:0]             csr_data
);

   hfag_item_type           front_item;
   logic [TASK_ID_BITS-1:0] front_task;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_valid;
   hfag_item_type           q_item;
   logic [TASK_ID_BITS-1:0] q_task;
   logic                    req_xfer;
   logic                    csr_we;

   // A request transfers whenever the queue has room.
   assign req_stall = q_full;
   assign req_xfer  = req_valid && !q_full;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   hfag_front #(
      .TASK_ID_BITS(TASK_ID_BITS)
   ) u_front (
      .req_action       (req_action),
      .req_task_id      (req_task_id),
      .req_has_own_class(req_has_own_class),
      .req_own_class    (req_own_class),
      .req_class_in     (req_class_in),
      .req_size         (req_size),
      .req_count        (req_count),
      .req_free_bytes   (req_free_bytes),
      .item             (front_item),
      .item_task        (front_task)
   );

   hfag_queue #(
      .TASK_ID_BITS(TASK_ID_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_xfer),
      .push_item(front_item),
      .push_task(front_task),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_item (q_item),
      .pop_task (q_task)
   );

   hfag_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_data         (csr_data),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_task           (q_task),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_class_before (rsp_class_before),
      .rsp_available    (rsp_available),
      .rsp_refusal_count(rsp_refusal_count)
   );

endmodule

/* design/hfag_front.sv */
// Front end: decodes the action and works out the byte demand of a request.
module hfag_front
   import hfag_pkg::*;
#(
   parameter int TASK_ID_BITS = 32
) (
   input  logic [2:0]              req_action,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   input  logic                    req_has_own_class,
   input  logic [1:0]              req_own_class,
   input  logic [1:0]              req_class_in,
   input  logic [31:0]             req_size,
   input  logic [31:0]             req_count,
   input  logic [31:0]             req_free_bytes,
   output hfag_item_type           item,
   output logic [TASK_ID_BITS-1:0] item_task
);

   hfag_ops_type ops;
   logic [63:0]  prod;

   // Decode the action; unused codes leave every flag low.
   always_comb begin
      ops = '0;
      case (req_action)
         ACT_CHECK_SIZE:  ops.chk = 1'b1;
         ACT_CHECK_COUNT: ops.mul = 1'b1;
         ACT_SET_CLASS:   ops.set = 1'b1;
         ACT_FORGET_TASK: ops.fgt = 1'b1;
         ACT_QUERY_AVAIL: ops.qry = 1'b1;
         default:         ops = '0;
      endcase
   end

   // Full 64-bit product; any high bit set means the array size overflows.
   assign prod = 64'(req_count) * 64'(req_size);

   // Pack the classified request for the queue.
   always_comb begin
      item.ops        = ops;
      item.own        = req_has_own_class;
      item.own_class  = req_own_class;
      item.class_in   = req_class_in;
      item.need       = ops.mul ? prod[31:0] : req_size;
      item.ovf        = ops.mul && (prod[63:32] != 32'd0);
      item.free_bytes = req_free_bytes;
   end

   assign item_task = req_task_id;

endmodule

/* design/hfag_queue.sv */
// Two-entry queue that decouples the request front from the table back end.
module hfag_queue
   import hfag_pkg::*;
#(
   parameter int TASK_ID_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hfag_item_type           push_item,
   input  logic [TASK_ID_BITS-1:0] push_task,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output hfag_item_type           pop_item,
   output logic [TASK_ID_BITS-1:0] pop_task
);

   localparam int DEPTH = 2;

   hfag_item_type           item_ff [DEPTH];
   logic [TASK_ID_BITS-1:0] task_ff [DEPTH];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;

   assign full      = (count_ff == 2'(DEPTH));
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = item_ff[rd_ptr_ff];
   assign pop_task  = task_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(pop);
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         task_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

/* design/hfag_back.sv */
// Back end: scans the class table, applies the floor and issues one result per request.
module hfag_back
   import hfag_pkg::*;
#(
   parameter int TABLE_ENTRIES = 8,
   parameter int TASK_ID_BITS  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [23:0]             csr_data,
   input  logic                    q_valid,
   input  hfag_item_type           q_item,
   input  logic [TASK_ID_BITS-1:0] q_task,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_granted,
   output logic [1:0]              rsp_class_before,
   output logic [31:0]             rsp_available,
   output logic [31:0]             rsp_refusal_count
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   // Table storage; an entry counts only while its valid bit is set.
   logic [TASK_ID_BITS-1:0] task_mem [TABLE_ENTRIES];
   logic [1:0]              class_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // Read pipeline of the scan.
   logic                    rd_live_ff;
   logic [TASK_ID_BITS-1:0] rd_task_ff;
   logic [1:0]              rd_class_ff;
   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_idx_ff;

   // Scan findings.
   logic                    found_ff;
   logic [IDX_W-1:0]        match_idx_ff;
   logic [1:0]              match_class_ff;
   logic                    empty_found_ff;
   logic [IDX_W-1:0]        empty_idx_ff;

   // Request in progress and intermediate results.
   hfag_item_type           item_ff;
   logic [TASK_ID_BITS-1:0] task_ff;
   logic [1:0]              cls_ff, cls_in;
   logic [1:0]              qcls;
   logic [24:0]             floor_sel;
   logic [32:0]             diff_ff, diff_in;

   logic [23:0]             floor_ff;
   logic [31:0]             refusals_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_granted_ff;
   logic [1:0]              rsp_class_ff;
   logic [31:0]             rsp_avail_ff;

   logic                    can_out;
   logic                    finish;
   logic                    breach;
   logic                    refuse;
   logic                    grant;
   logic                    set_en;
   logic                    tbl_we;
   logic [IDX_W-1:0]        tbl_waddr;
   logic                    tbl_clear;
   logic [31:0]             avail_val;

   assign q_pop   = (state_ff == ST_IDLE) && q_valid;
   assign can_out = !rsp_valid_ff || !rsp_stall;
   assign finish  = (state_ff == ST_DONE) && can_out;

   // Sequencer: pop, scan every entry, work out the floor, then report.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (q_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: state_in = ST_CALC;
         ST_CALC:  state_in = ST_DONE;
         ST_DONE: begin
            if (can_out) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Caller class and the floor of the class that the result reports against.
   always_comb begin
      cls_in = item_ff.own ? item_ff.own_class :
               (found_ff ? match_class_ff : CLASS_SYSTEM);
      qcls   = item_ff.ops.qry ? item_ff.class_in : cls_in;
      if (floor_ff == 24'd0) begin
         floor_sel = 25'd0;
      end else if (qcls == CLASS_GENERAL) begin
         floor_sel = {1'b0, floor_ff} + RT_RESERVE;
      end else if (qcls == CLASS_REALTIME) begin
         floor_sel = {1'b0, floor_ff};
      end else begin
         floor_sel = {2'b00, floor_ff[23:1]};
      end
      diff_in = {1'b0, item_ff.free_bytes} - {8'd0, floor_sel};
   end

   // Admission decision and table update of the finishing request.
   always_comb begin
      breach    = (floor_ff != 24'd0) && (diff_ff[32] || (item_ff.need > diff_ff[31:0]));
      refuse    = (item_ff.ops.chk && breach) ||
                  (item_ff.ops.mul && (item_ff.ovf || breach));
      grant     = (item_ff.ops.chk || item_ff.ops.mul) && !refuse;
      avail_val = (!diff_ff[32] && (diff_ff[31:0] != 32'd0)) ? diff_ff[31:0] : 32'd0;
      set_en    = item_ff.ops.set && !item_ff.own && (task_ff != '0);
      tbl_we    = finish && set_en && (item_ff.class_in != CLASS_SYSTEM) &&
                  (found_ff || empty_found_ff);
      tbl_waddr = found_ff ? match_idx_ff : empty_idx_ff;
      tbl_clear = finish && found_ff &&
                  ((set_en && (item_ff.class_in == CLASS_SYSTEM)) ||
                   (item_ff.ops.fgt && (task_ff != '0)));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rd_live_ff   <= 1'b0;
         valid_ff     <= '0;
         floor_ff     <= 24'd0;
         refusals_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rd_live_ff <= (state_ff == ST_SCAN);
         if (tbl_we) begin
            valid_ff[tbl_waddr] <= 1'b1;
         end else if (tbl_clear) begin
            valid_ff[match_idx_ff] <= 1'b0;
         end
         if (csr_we) begin
            floor_ff    <= csr_data;
            refusals_ff <= 32'd0;
         end else if (finish) begin
            refusals_ff <= refusals_ff + 32'(refuse);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Table memory: one write port, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         task_mem[tbl_waddr]  <= task_ff;
         class_mem[tbl_waddr] <= item_ff.class_in;
      end
      rd_task_ff  <= task_mem[idx_ff];
      rd_class_ff <= class_mem[idx_ff];
      rd_valid_ff <= valid_ff[idx_ff];
      rd_idx_ff   <= idx_ff;
   end

   // Request capture, scan compare and result registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff        <= q_item;
         task_ff        <= q_task;
         found_ff       <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (rd_live_ff) begin
         if (rd_valid_ff && (rd_task_ff == task_ff) && !found_ff) begin
            found_ff       <= 1'b1;
            match_idx_ff   <= rd_idx_ff;
            match_class_ff <= rd_class_ff;
         end
         if (!rd_valid_ff && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= rd_idx_ff;
         end
      end
      if (state_ff == ST_CALC) begin
         cls_ff  <= cls_in;
         diff_ff <= diff_in;
      end
      if (finish) begin
         rsp_granted_ff <= grant;
         rsp_class_ff   <= cls_ff;
         rsp_avail_ff   <= avail_val;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_class_before  = rsp_class_ff;
   assign rsp_available     = rsp_avail_ff;
   assign rsp_refusal_count = refusals_ff;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the heap floor admission gate: directed table, then random traffic.
module testbench
   import hfag_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 11;
   localparam int TABLE_DEPTH  = 8;
   // A request passes the queue, the full table scan and the floor step before its result is valid.
   localparam int DRAIN_CYCLES = 24;
   localparam int CHUNKS       = 14;
   localparam int CHUNK_ITEMS  = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int POOL_SIZE    = 12;
   localparam int TIMEOUT_NS   = 2_000_000;

   // Codes the package leaves unnamed.
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam logic [1:0] CLASS_SPARE   = 2'd3;

   typedef struct packed {
      logic        granted;
      logic [1:0]  class_before;
      logic [31:0] available;
      logic [31:0] refusal_count;
   } outcome_type;

   // One line of stimulus: either a floor write or a request.
   typedef struct {
      bit          is_floor;
      logic [23:0] floor_val;
      logic [2:0]  action;
      logic [31:0] task_id;
      logic        own;
      logic [1:0]  own_class;
      logic [1:0]  class_in;
      logic [31:0] size;
      logic [31:0] count;
      logic [31:0] free;
      bit          pinned;
      outcome_type pinned_out;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [31:0] req_task_id = '0;
   logic        req_has_own_class = 1'b0;
   logic [1:0]  req_own_class = '0;
   logic [1:0]  req_class_in = '0;
   logic [31:0] req_size = '0;
   logic [31:0] req_count = '0;
   logic [31:0] req_free_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [1:0]  rsp_class_before;
   logic [31:0] rsp_available;
   logic [31:0] rsp_refusal_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_data = '0;

   // Typed expectation that travels with the payload of a directed row.
   bit          req_pinned = 1'b0;
   outcome_type req_pinned_out = '0;

   // Idle and hold-off controls.
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   bit          hold_on = 1'b0;
   bit          pressure_go = 1'b0;

   int          errors = 0;
   int          items_sent = 0;
   int          floor_writes = 0;
   int          grants = 0;
   int          input_stall_cycles = 0;

   // Predicted state of the gate.
   logic [23:0] mdl_floor = '0;
   logic [31:0] mdl_refusals = '0;
   logic [31:0] tbl_task [TABLE_DEPTH] = '{default: '0};
   logic [1:0]  tbl_class [TABLE_DEPTH] = '{default: '0};
   outcome_type pending_outcomes [$];

   stim_row_type plan [$];
   logic [23:0] cur_floor = '0;
   logic [31:0] task_pool [POOL_SIZE];

   heap_floor_admission_gate dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_task_id       (req_task_id),
      .req_has_own_class (req_has_own_class),
      .req_own_class     (req_own_class),
      .req_class_in      (req_class_in),
      .req_size          (req_size),
      .req_count         (req_count),
      .req_free_bytes    (req_free_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted       (rsp_granted),
      .rsp_class_before  (rsp_class_before),
      .rsp_available     (rsp_available),
      .rsp_refusal_count (rsp_refusal_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Floor that applies to a class under a given floor setting.
   function automatic logic [31:0] floor_level(input logic [23:0] fl, input logic [1:0] cls);
      if (fl == '0) return '0;
      case (cls)
         CLASS_GENERAL:  return {8'd0, fl} + 32'(RT_RESERVE);
         CLASS_REALTIME: return {8'd0, fl};
         default:        return {9'd0, fl[23:1]};
      endcase
   endfunction

   // True when taking need bytes would cut into the class floor.
   function automatic logic over_floor(input logic [31:0] need, input logic [1:0] cls,
                                       input logic [31:0] heap_left);
      logic [31:0] f;
      if (mdl_floor == '0) return 1'b0;
      f = floor_level(mdl_floor, cls);
      if (heap_left < f) return 1'b1;
      return need > heap_left - f;
   endfunction

   // Admission decision for one request; updates the predicted table and counter.
   function automatic outcome_type gate_outcome(input stim_row_type r);
      outcome_type o;
      logic [1:0]  cls;
      logic [31:0] fl;
      logic [63:0] prod;
      int          slot;
      int          empty;
      logic        found;
      cls = CLASS_SYSTEM;
      found = 1'b0;
      if (r.own) begin
         cls = r.own_class;
      end else if (r.task_id != '0) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!found && tbl_task[i] == r.task_id) begin
               cls = tbl_class[i];
               found = 1'b1;
            end
         end
      end
      fl = floor_level(mdl_floor, (r.action == ACT_QUERY_AVAIL) ? r.class_in : cls);
      o = '0;
      case (r.action)
         ACT_CHECK_SIZE: begin
            if (over_floor(r.size, cls, r.free)) mdl_refusals++;
            else o.granted = 1'b1;
         end
         ACT_CHECK_COUNT: begin
            // A product wider than 32 bits is refused even with no floor.
            prod = {32'd0, r.count} * {32'd0, r.size};
            if (prod[63:32] != '0 || over_floor(prod[31:0], cls, r.free)) mdl_refusals++;
            else o.granted = 1'b1;
         end
         ACT_SET_CLASS: begin
            // Kernel threads carry their class, so only table callers change the table.
            if (!r.own && r.task_id != '0) begin
               slot = -1;
               empty = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (slot < 0) begin
                     if (tbl_task[i] == r.task_id) slot = i;
                     else if (tbl_task[i] == '0 && empty < 0) empty = i;
                  end
               end
               if (r.class_in == CLASS_SYSTEM) begin
                  if (slot >= 0) tbl_task[slot] = '0;
               end else begin
                  // A full table leaves the task at system.
                  if (slot < 0) slot = empty;
                  if (slot >= 0) begin
                     tbl_task[slot] = r.task_id;
                     tbl_class[slot] = r.class_in;
                  end
               end
            end
         end
         ACT_FORGET_TASK: begin
            if (r.task_id != '0) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (tbl_task[i] == r.task_id) tbl_task[i] = '0;
               end
            end
         end
         default: ;
      endcase
      o.class_before = cls;
      o.available = (r.free > fl) ? r.free - fl : '0;
      o.refusal_count = mdl_refusals;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
   endtask

   // Watch all three channels; results retire expectations before new requests add them.
   always @(posedge clock) begin : watch
      stim_row_type seen;
      outcome_type  want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_granted !== want.granted)
                  report_mismatch($sformatf("granted %0d, expected %0d",
                                            rsp_granted, want.granted));
               if (rsp_class_before !== want.class_before)
                  report_mismatch($sformatf("class_before %0d, expected %0d",
                                            rsp_class_before, want.class_before));
               if (rsp_available !== want.available)
                  report_mismatch($sformatf("available %h, expected %h",
                                            rsp_available, want.available));
               if (rsp_refusal_count !== want.refusal_count)
                  report_mismatch($sformatf("refusal_count %0d, expected %0d",
                                            rsp_refusal_count, want.refusal_count));
            end
            if (rsp_granted === 1'b1) grants++;
         end
         // A floor write also clears the refusal counter.
         if (csr_valid && csr_ready) begin
            mdl_floor = csr_data;
            mdl_refusals = '0;
         end
         if (req_valid && !req_stall) begin
            seen = '{default: '0};
            seen.action = req_action;
            seen.task_id = req_task_id;
            seen.own = req_has_own_class;
            seen.own_class = req_own_class;
            seen.class_in = req_class_in;
            seen.size = req_size;
            seen.count = req_count;
            seen.free = req_free_bytes;
            want = gate_outcome(seen);
            if (req_pinned) want = req_pinned_out;
            pending_outcomes.push_back(want);
         end else if (req_valid) begin
            input_stall_cycles++;
         end
      end
   end

   // Result side stalls at random, or solidly while a long hold-off is on.
   always @(posedge clock) begin
      rsp_stall <= !reset && (hold_on || ($urandom_range(99) < recv_gap_pct));
   end

   // Long hold-off on the result side, so the gate fills and stalls its input.
   initial begin : long_hold
      wait (pressure_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   function automatic void add_req(input logic [2:0] action, input logic [31:0] task_id,
                                   input logic own, input logic [1:0] own_class,
                                   input logic [1:0] class_in, input logic [31:0] size,
                                   input logic [31:0] count, input logic [31:0] free);
      stim_row_type r;
      r = '{default: '0};
      r.action = action;
      r.task_id = task_id;
      r.own = own;
      r.own_class = own_class;
      r.class_in = class_in;
      r.size = size;
      r.count = count;
      r.free = free;
      plan.push_back(r);
   endfunction

   // Attach a result that can be read off at a glance to the last row.
   function automatic void pin(input logic granted, input logic [1:0] cls,
                               input logic [31:0] available, input logic [31:0] refusals);
      plan[plan.size() - 1].pinned = 1'b1;
      plan[plan.size() - 1].pinned_out = '{granted, cls, available, refusals};
   endfunction

   function automatic void add_floor(input logic [23:0] v);
      stim_row_type r;
      r = '{default: '0};
      r.is_floor = 1'b1;
      r.floor_val = v;
      plan.push_back(r);
   endfunction

   // Random request: a small pool of task handles keeps table hits frequent.
   function automatic stim_row_type draw_request();
      stim_row_type r;
      int          pick;
      logic [31:0] base;
      r = '{default: '0};
      pick = $urandom_range(99);
      if (pick < 25) r.action = ACT_CHECK_SIZE;
      else if (pick < 45) r.action = ACT_CHECK_COUNT;
      else if (pick < 70) r.action = ACT_SET_CLASS;
      else if (pick < 80) r.action = ACT_FORGET_TASK;
      else if (pick < 95) r.action = ACT_QUERY_AVAIL;
      else r.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      r.task_id = ($urandom_range(19) == 0) ? $urandom : task_pool[$urandom_range(POOL_SIZE - 1)];
      r.own = ($urandom_range(9) == 0);
      r.own_class = 2'($urandom_range(3));
      r.class_in = 2'($urandom_range(3));
      case ($urandom_range(3))
         0:       r.size = $urandom;
         1:       r.size = $urandom_range(16);
         default: r.size = $urandom_range(20000);
      endcase
      // Counts are random, small, moderate or near the overflow boundary for the size at hand.
      case ($urandom_range(3))
         0:       r.count = $urandom;
         1:       r.count = $urandom_range(8);
         2:       r.count = (r.size != '0) ? 32'hFFFF_FFFF / r.size + 32'($urandom_range(1))
                                           : $urandom;
         default: r.count = $urandom_range(70000);
      endcase
      // Free memory mostly close to one of the class floors.
      if ($urandom_range(9) < 4) begin
         r.free = $urandom;
      end else begin
         base = floor_level(cur_floor, 2'($urandom_range(3)));
         r.free = base + 32'($urandom_range(40000)) - 32'd20000;
      end
      return r;
   endfunction

   // Offer one request and hold it until the gate takes the transfer.
   task automatic offer(input stim_row_type r);
      req_valid <= 1'b1;
      req_action <= r.action;
      req_task_id <= r.task_id;
      req_has_own_class <= r.own;
      req_own_class <= r.own_class;
      req_class_in <= r.class_in;
      req_size <= r.size;
      req_count <= r.count;
      req_free_bytes <= r.free;
      req_pinned <= r.pinned;
      req_pinned_out <= r.pinned_out;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every result is in and the back end is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_floor(input logic [23:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_floor = v;
      floor_writes++;
   endtask

   initial begin : stimulus
      int k;
      task_pool[0] = '0;
      task_pool[1] = '1;
      for (k = 2; k < POOL_SIZE; k++) task_pool[k] = $urandom;

      // Zero floor: queries, checks that always pass, overflow, unused actions.
      add_req(ACT_QUERY_AVAIL, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, '1);
      pin(1'b0, CLASS_SYSTEM, 32'hFFFF_FFFF, 32'd0);
      add_req(ACT_CHECK_SIZE, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '1, '0, '0);
      pin(1'b1, CLASS_SYSTEM, 32'd0, 32'd0);
      add_req(ACT_CHECK_COUNT, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM,
              32'h1_0000, 32'h1_0000, 32'd1000);
      pin(1'b0, CLASS_SYSTEM, 32'd1000, 32'd1);
      add_req(ACT_CHECK_COUNT, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '1, '0, 32'd1000);
      pin(1'b1, CLASS_SYSTEM, 32'd1000, 32'd1);
      add_req(ACT_UNUSED_LO, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd5, 32'd5, 32'd77);
      pin(1'b0, CLASS_SYSTEM, 32'd77, 32'd1);
      add_req(ACT_UNUSED_HI, '1, 1'b1, CLASS_SPARE, CLASS_SPARE, '1, '1, '0);
      pin(1'b0, CLASS_SPARE, 32'd0, 32'd1);

      // Small floor: class table behavior and headroom checks.
      add_floor(24'h00_1000);
      add_req(ACT_SET_CLASS, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_GENERAL, '0, '0, 32'd50000);
      add_req(ACT_CHECK_SIZE, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, 32'd12288);
      add_req(ACT_CHECK_SIZE, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, 32'd12287);
      add_req(ACT_CHECK_SIZE, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd7713, '0, 32'd20000);
      add_req(ACT_SET_CLASS, 32'h22, 1'b1, CLASS_REALTIME, CLASS_REALTIME, '0, '0, 32'd9000);
      add_req(ACT_QUERY_AVAIL, 32'h22, 1'b0, CLASS_SYSTEM, CLASS_SPARE, '0, '0, 32'd3000);
      add_req(ACT_SET_CLASS, '0, 1'b0, CLASS_SYSTEM, CLASS_GENERAL, '0, '0, 32'd3000);
      add_req(ACT_FORGET_TASK, '0, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, 32'd3000);
      add_req(ACT_SET_CLASS, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, 32'd3000);
      add_req(ACT_CHECK_SIZE, 32'h11, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd100, '0, 32'd2148);
      // Fill every entry, then one more task finds the table full.
      for (k = 1; k <= TABLE_DEPTH; k++)
         add_req(ACT_SET_CLASS, 32'h100 + k, 1'b0, CLASS_SYSTEM, CLASS_REALTIME,
                 '0, '0, 32'(k * 1000));
      add_req(ACT_SET_CLASS, '1, 1'b0, CLASS_SYSTEM, CLASS_REALTIME, '0, '0, 32'd5000);
      add_req(ACT_CHECK_SIZE, '1, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd10, '0, 32'd5000);
      add_req(ACT_FORGET_TASK, 32'h104, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, '0, '0, 32'd5000);
      add_req(ACT_SET_CLASS, '1, 1'b0, CLASS_SYSTEM, CLASS_SPARE, '0, '0, 32'd5000);
      add_req(ACT_CHECK_COUNT, '1, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd3, 32'd1000, 32'd6000);

      // Largest floor with the largest demands.
      add_floor(24'hFF_FFFF);
      add_req(ACT_CHECK_SIZE, '0, 1'b1, CLASS_GENERAL, CLASS_SYSTEM, '1, '0, '1);
      add_req(ACT_CHECK_COUNT, 32'h101, 1'b0, CLASS_SYSTEM, CLASS_SYSTEM, 32'd1, '1, '1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_floor) write_floor(plan[i].floor_val);
         else offer(plan[i]);
      end

      // Random traffic in chunks, each under its own floor setting.
      for (k = 0; k < CHUNKS; k++) begin
         if (k < 5) begin
            send_gap_pct = 7;
            recv_gap_pct = 56;
         end else if (k < 10) begin
            send_gap_pct = 56;
            recv_gap_pct = 7;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         case (k % 5)
            0:       write_floor(24'($urandom));
            1:       write_floor(24'h00_0000);
            2:       write_floor(24'hFF_FFFF);
            3:       write_floor(24'($urandom_range(1, 20000)));
            default: write_floor(24'($urandom_range(8192, 70000)));
         endcase
         if (k == CHUNKS - 2) pressure_go = 1'b1;
         repeat (CHUNK_ITEMS) offer(draw_request());
      end

      settle();
      $display("Covered %0d requests under %0d floor settings; %0d allocation checks granted.",
               items_sent, floor_writes, grants);
      $display("The request side was held off for %0d cycles while results backed up.",
               input_stall_cycles);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/hfag_pkg.sv
design/hfag_front.sv
design/hfag_queue.sv
design/hfag_back.sv
design/heap_floor_admission_gate.sv
sim/testbench.sv
